@@ rtl/core/jukebox_platter_lun_manager_assert.svh @@
// Assertion macros shared by the platter manager modules.
`ifndef JUKEBOX_PLATTER_LUN_MANAGER_ASSERT_SVH
`define JUKEBOX_PLATTER_LUN_MANAGER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define JPLM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define JPLM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/jplm_pkg.sv @@
// Shared types, codes and constants of the jukebox platter LUN manager.
package jplm_pkg;

  localparam int PLATTERS_DEF = 100;
  localparam int LUNS_DEF     = 2;

  localparam int PLAT_W      = 7;
  localparam int LUN_W       = 3;
  localparam int ACT_W       = 3;
  localparam int TIME_W      = 32;
  localparam int ST_W        = 2;
  localparam int MAX_RES     = 5;
  localparam int HIT_W       = 3;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;
  localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd600;

  // register index, taken from paddr[2]
  localparam logic REG_IDLE_TIMEOUT = 1'b0;

  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_PROBE  = 1'b1;

  localparam logic [ST_W-1:0] ST_UNLOADED = 2'd0;
  localparam logic [ST_W-1:0] ST_STOPPED  = 2'd1;
  localparam logic [ST_W-1:0] ST_SPINNING = 2'd2;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE    = 3'd0,
    ACT_STOP    = 3'd1,
    ACT_RELEASE = 3'd2,
    ACT_SET     = 3'd3,
    ACT_MODESEL = 3'd4,
    ACT_START   = 3'd5,
    ACT_BAD     = 3'd6
  } act_t;

  typedef struct packed {
    logic [ST_W-1:0]   st;
    logic [LUN_W-1:0]  lun;
    logic [TIME_W-1:0] la;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_PCHK,
    S_CHK,
    S_STOP,
    S_REL,
    S_SET,
    S_MSEL,
    S_START,
    S_NONE,
    S_BAD,
    S_FLUSH
  } state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SCAN0,
    OP_RD_PLAT,
    OP_PCHK,
    OP_NEXT,
    OP_STOP,
    OP_REL,
    OP_HIT,
    OP_FLUSH,
    OP_BAD,
    OP_SET,
    OP_MSEL,
    OP_START,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t op;
  } ctl_t;

  typedef struct packed {
    logic            out_free;
    logic            probe;
    logic            bad;
    logic [ST_W-1:0] ent_st;
    logic            match;
    logic            hit;
    logic            idx_last;
    logic            hits_full;
    logic            pend_v;
  } sts_t;

  // true when the operation loads the output register
  function automatic logic op_emits(op_t op, logic pend_v);
    logic r;
    case (op)
      OP_STOP, OP_REL, OP_FLUSH, OP_BAD, OP_SET, OP_MSEL, OP_START, OP_NONE: r = 1'b1;
      OP_HIT:  r = pend_v;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/jplm_ctrl.sv @@
// Sequencer FSM: walks each request through lookup, scan and command emission.
`include "jukebox_platter_lun_manager_assert.svh"

module jplm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  jplm_pkg::sts_t  sts,
  output jplm_pkg::ctl_t  ctl
);

  jplm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jplm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != jplm_pkg::S_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      jplm_pkg::S_IDLE: begin
        if (in_valid) state_nxt = jplm_pkg::S_DEC;
      end
      jplm_pkg::S_DEC: begin
        if (sts.probe)    state_nxt = jplm_pkg::S_CHK;
        else if (sts.bad) state_nxt = jplm_pkg::S_BAD;
        else              state_nxt = jplm_pkg::S_PCHK;
      end
      jplm_pkg::S_PCHK: begin
        if (sts.ent_st == jplm_pkg::ST_UNLOADED)     state_nxt = jplm_pkg::S_CHK;
        else if (sts.ent_st == jplm_pkg::ST_STOPPED) state_nxt = jplm_pkg::S_START;
        else                                         state_nxt = jplm_pkg::S_NONE;
      end
      jplm_pkg::S_CHK: begin
        if (sts.probe) begin
          if (sts.hit) begin
            if (!sts.pend_v || sts.out_free) begin
              if (sts.idx_last || sts.hits_full) state_nxt = jplm_pkg::S_FLUSH;
            end
          end else if (sts.idx_last) begin
            state_nxt = jplm_pkg::S_FLUSH;
          end
        end else begin
          if (sts.match) begin
            state_nxt = (sts.ent_st == jplm_pkg::ST_SPINNING) ? jplm_pkg::S_STOP
                                                               : jplm_pkg::S_REL;
          end else if (sts.idx_last) begin
            state_nxt = jplm_pkg::S_SET;
          end
        end
      end
      jplm_pkg::S_STOP: begin
        if (sts.out_free) state_nxt = jplm_pkg::S_REL;
      end
      jplm_pkg::S_REL: begin
        if (sts.out_free) state_nxt = sts.idx_last ? jplm_pkg::S_SET : jplm_pkg::S_CHK;
      end
      jplm_pkg::S_SET: begin
        if (sts.out_free) state_nxt = jplm_pkg::S_MSEL;
      end
      jplm_pkg::S_MSEL: begin
        if (sts.out_free) state_nxt = jplm_pkg::S_START;
      end
      jplm_pkg::S_START, jplm_pkg::S_NONE, jplm_pkg::S_BAD, jplm_pkg::S_FLUSH: begin
        if (sts.out_free) state_nxt = jplm_pkg::S_IDLE;
      end
      default: state_nxt = jplm_pkg::S_IDLE;
    endcase
  end

  // datapath command
  always_comb begin
    ctl.op = jplm_pkg::OP_NOP;
    unique case (state_r)
      jplm_pkg::S_IDLE: begin
        if (in_valid) ctl.op = jplm_pkg::OP_LOAD;
      end
      jplm_pkg::S_DEC: begin
        if (sts.probe)     ctl.op = jplm_pkg::OP_SCAN0;
        else if (!sts.bad) ctl.op = jplm_pkg::OP_RD_PLAT;
      end
      jplm_pkg::S_PCHK: ctl.op = jplm_pkg::OP_PCHK;
      jplm_pkg::S_CHK: begin
        if (sts.probe) begin
          if (sts.hit) begin
            // a held hit goes out first, so the output slot must be free
            if (!sts.pend_v || sts.out_free) ctl.op = jplm_pkg::OP_HIT;
          end else if (!sts.idx_last) begin
            ctl.op = jplm_pkg::OP_NEXT;
          end
        end else if (!sts.match && !sts.idx_last) begin
          ctl.op = jplm_pkg::OP_NEXT;
        end
      end
      jplm_pkg::S_STOP:  if (sts.out_free) ctl.op = jplm_pkg::OP_STOP;
      jplm_pkg::S_REL:   if (sts.out_free) ctl.op = jplm_pkg::OP_REL;
      jplm_pkg::S_SET:   if (sts.out_free) ctl.op = jplm_pkg::OP_SET;
      jplm_pkg::S_MSEL:  if (sts.out_free) ctl.op = jplm_pkg::OP_MSEL;
      jplm_pkg::S_START: if (sts.out_free) ctl.op = jplm_pkg::OP_START;
      jplm_pkg::S_NONE:  if (sts.out_free) ctl.op = jplm_pkg::OP_NONE;
      jplm_pkg::S_BAD:   if (sts.out_free) ctl.op = jplm_pkg::OP_BAD;
      jplm_pkg::S_FLUSH: if (sts.out_free) ctl.op = jplm_pkg::OP_FLUSH;
      default:           ctl.op = jplm_pkg::OP_NOP;
    endcase
  end

  `JPLM_ASSERT_IMP(a_emit_free, jplm_pkg::op_emits(ctl.op, sts.pend_v), sts.out_free, "emit while output busy")
  `JPLM_ASSERT_NXT(a_accept_dec, in_valid && !in_stall, state_r == jplm_pkg::S_DEC, "accepted request not decoded")
  `JPLM_ASSERT_IMP(a_flush_probe, state_r == jplm_pkg::S_FLUSH, sts.probe, "flush outside a probe")

endmodule

@@ rtl/core/jplm_dp.sv @@
// Datapath: platter table memory, scan index, request latch and output register.
`include "jukebox_platter_lun_manager_assert.svh"

module jplm_dp #(
  parameter int PLATTERS = jplm_pkg::PLATTERS_DEF,
  parameter int LUNS     = jplm_pkg::LUNS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_command,
  input  logic [jplm_pkg::PLAT_W-1:0]   in_platter,
  input  logic [jplm_pkg::TIME_W-1:0]   in_now,
  input  logic [jplm_pkg::TIME_W-1:0]   idle_timeout,
  input  jplm_pkg::ctl_t                ctl,
  output jplm_pkg::sts_t                sts,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [jplm_pkg::ACT_W-1:0]    out_action,
  output logic [jplm_pkg::LUN_W-1:0]    out_drive_lun,
  output logic [jplm_pkg::PLAT_W-1:0]   out_target_platter,
  output logic                          out_last
);

  localparam int IDX_W = $clog2(PLATTERS);

  // platter table
  jplm_pkg::ent_t mem_r [PLATTERS];
  logic [PLATTERS-1:0] vld_r, vld_nxt;
  jplm_pkg::ent_t rd_q_r;
  logic           rd_ok_r;

  logic                        rd_en, wr_en;
  logic [IDX_W-1:0]            rd_addr, wr_addr;
  jplm_pkg::ent_t              wr_data, ent;

  // request and scan state
  logic                        cmd_r, cmd_nxt;
  logic [jplm_pkg::PLAT_W-1:0] plat_r, plat_nxt;
  logic [jplm_pkg::TIME_W-1:0] now_r, now_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt, idx_inc;
  logic [jplm_pkg::LUN_W-1:0]  next_lun_r, next_lun_nxt;
  logic [jplm_pkg::LUN_W:0]    nl_inc;
  logic [jplm_pkg::LUN_W-1:0]  work_lun_r, work_lun_nxt;
  logic [jplm_pkg::ST_W-1:0]   plat_st_r, plat_st_nxt;
  logic [jplm_pkg::HIT_W-1:0]  hits_r, hits_nxt;
  logic                        pend_v_r, pend_v_nxt;
  logic [jplm_pkg::LUN_W-1:0]  pend_lun_r, pend_lun_nxt;
  logic [jplm_pkg::PLAT_W-1:0] pend_plat_r, pend_plat_nxt;

  // output register
  logic                        ov_r, ov_nxt;
  logic [jplm_pkg::ACT_W-1:0]  oact_r, oact_nxt;
  logic [jplm_pkg::LUN_W-1:0]  olun_r, olun_nxt;
  logic [jplm_pkg::PLAT_W-1:0] oplat_r, oplat_nxt;
  logic                        olast_r, olast_nxt;

  logic                        emit, e_last, out_free, idx_last, hits_full, advance;
  jplm_pkg::act_t              e_act;
  logic [jplm_pkg::LUN_W-1:0]  e_lun;
  logic [jplm_pkg::PLAT_W-1:0] e_plat;
  logic [jplm_pkg::TIME_W-1:0] idle;

  // never-written entries read as the reset value
  assign ent       = rd_ok_r ? rd_q_r : '0;
  assign idx_inc   = idx_r + IDX_W'(1);
  assign idx_last  = (idx_r == IDX_W'(PLATTERS - 1));
  assign hits_full = (hits_r == jplm_pkg::HIT_W'(jplm_pkg::MAX_RES - 1));
  assign idle      = now_r - ent.la;
  assign out_free  = !ov_r || !out_stall;
  assign nl_inc    = {1'b0, next_lun_r} + (jplm_pkg::LUN_W + 1)'(1);

  assign sts.out_free  = out_free;
  assign sts.probe     = (cmd_r == jplm_pkg::CMD_PROBE);
  assign sts.bad       = (8'(plat_r) >= 8'(PLATTERS));
  assign sts.ent_st    = ent.st;
  assign sts.match     = (ent.st != jplm_pkg::ST_UNLOADED) && (ent.lun == work_lun_r);
  assign sts.hit       = (ent.st == jplm_pkg::ST_SPINNING) && (idle > idle_timeout);
  assign sts.idx_last  = idx_last;
  assign sts.hits_full = hits_full;
  assign sts.pend_v    = pend_v_r;

  always_comb begin
    cmd_nxt       = cmd_r;
    plat_nxt      = plat_r;
    now_nxt       = now_r;
    idx_nxt       = idx_r;
    next_lun_nxt  = next_lun_r;
    work_lun_nxt  = work_lun_r;
    plat_st_nxt   = plat_st_r;
    hits_nxt      = hits_r;
    pend_v_nxt    = pend_v_r;
    pend_lun_nxt  = pend_lun_r;
    pend_plat_nxt = pend_plat_r;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = idx_r;
    wr_data = ent;
    advance = 1'b0;
    emit    = 1'b0;
    e_act   = jplm_pkg::ACT_NONE;
    e_lun   = '0;
    e_plat  = '0;
    e_last  = 1'b0;

    unique case (ctl.op)
      jplm_pkg::OP_LOAD: begin
        cmd_nxt    = in_command;
        plat_nxt   = in_platter;
        now_nxt    = in_now;
        hits_nxt   = '0;
        pend_v_nxt = 1'b0;
      end
      jplm_pkg::OP_SCAN0: begin
        rd_en   = 1'b1;
        idx_nxt = '0;
      end
      jplm_pkg::OP_RD_PLAT: begin
        rd_en   = 1'b1;
        rd_addr = plat_r[IDX_W-1:0];
      end
      jplm_pkg::OP_PCHK: begin
        plat_st_nxt = ent.st;
        if (ent.st == jplm_pkg::ST_UNLOADED) begin
          work_lun_nxt = next_lun_r;
          rd_en        = 1'b1;
          idx_nxt      = '0;
        end else begin
          work_lun_nxt = ent.lun;
        end
      end
      jplm_pkg::OP_NEXT: advance = 1'b1;
      jplm_pkg::OP_STOP: begin
        emit   = 1'b1;
        e_act  = jplm_pkg::ACT_STOP;
        e_lun  = work_lun_r;
        e_plat = jplm_pkg::PLAT_W'(idx_r);
      end
      jplm_pkg::OP_REL: begin
        emit       = 1'b1;
        e_act      = jplm_pkg::ACT_RELEASE;
        e_lun      = work_lun_r;
        e_plat     = jplm_pkg::PLAT_W'(idx_r);
        wr_en      = 1'b1;
        wr_data.st = jplm_pkg::ST_UNLOADED;
        advance    = !idx_last;
      end
      jplm_pkg::OP_HIT: begin
        // hold each stop one step so the final one can carry last
        emit          = pend_v_r;
        e_act         = jplm_pkg::ACT_STOP;
        e_lun         = pend_lun_r;
        e_plat        = pend_plat_r;
        pend_v_nxt    = 1'b1;
        pend_lun_nxt  = ent.lun;
        pend_plat_nxt = jplm_pkg::PLAT_W'(idx_r);
        hits_nxt      = hits_r + jplm_pkg::HIT_W'(1);
        wr_en         = 1'b1;
        wr_data.st    = jplm_pkg::ST_STOPPED;
        advance       = !idx_last && !hits_full;
      end
      jplm_pkg::OP_FLUSH: begin
        emit   = 1'b1;
        e_last = 1'b1;
        if (pend_v_r) begin
          e_act  = jplm_pkg::ACT_STOP;
          e_lun  = pend_lun_r;
          e_plat = pend_plat_r;
        end
      end
      jplm_pkg::OP_BAD: begin
        emit   = 1'b1;
        e_act  = jplm_pkg::ACT_BAD;
        e_plat = plat_r;
        e_last = 1'b1;
      end
      jplm_pkg::OP_SET: begin
        emit         = 1'b1;
        e_act        = jplm_pkg::ACT_SET;
        e_lun        = work_lun_r;
        e_plat       = plat_r;
        next_lun_nxt = (nl_inc >= (jplm_pkg::LUN_W + 1)'(LUNS)) ? '0
                                                                : nl_inc[jplm_pkg::LUN_W-1:0];
      end
      jplm_pkg::OP_MSEL: begin
        emit   = 1'b1;
        e_act  = jplm_pkg::ACT_MODESEL;
        e_lun  = work_lun_r;
        e_plat = plat_r;
      end
      jplm_pkg::OP_START: begin
        emit    = 1'b1;
        e_act   = jplm_pkg::ACT_START;
        e_lun   = work_lun_r;
        e_plat  = plat_r;
        e_last  = 1'b1;
        wr_en   = 1'b1;
        wr_addr = plat_r[IDX_W-1:0];
        wr_data = '{st: jplm_pkg::ST_SPINNING, lun: work_lun_r, la: now_r};
      end
      jplm_pkg::OP_NONE: begin
        emit    = 1'b1;
        e_act   = jplm_pkg::ACT_NONE;
        e_lun   = work_lun_r;
        e_plat  = plat_r;
        e_last  = 1'b1;
        wr_en   = 1'b1;
        wr_addr = plat_r[IDX_W-1:0];
        wr_data = '{st: plat_st_r, lun: work_lun_r, la: now_r};
      end
      default: ;
    endcase

    if (advance) begin
      rd_en   = 1'b1;
      rd_addr = idx_inc;
      idx_nxt = idx_inc;
    end

    vld_nxt = vld_r;
    if (wr_en) vld_nxt[wr_addr] = 1'b1;

    ov_nxt    = ov_r;
    oact_nxt  = oact_r;
    olun_nxt  = olun_r;
    oplat_nxt = oplat_r;
    olast_nxt = olast_r;
    if (emit) begin
      ov_nxt    = 1'b1;
      oact_nxt  = e_act;
      olun_nxt  = e_lun;
      oplat_nxt = e_plat;
      olast_nxt = e_last;
    end else if (!out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_q_r  <= mem_r[rd_addr];
      rd_ok_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      next_lun_r <= '0;
      ov_r       <= 1'b0;
      pend_v_r   <= 1'b0;
      hits_r     <= '0;
      cmd_r      <= jplm_pkg::CMD_ACCESS;
    end else begin
      vld_r      <= vld_nxt;
      next_lun_r <= next_lun_nxt;
      ov_r       <= ov_nxt;
      pend_v_r   <= pend_v_nxt;
      hits_r     <= hits_nxt;
      cmd_r      <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    plat_r      <= plat_nxt;
    now_r       <= now_nxt;
    idx_r       <= idx_nxt;
    work_lun_r  <= work_lun_nxt;
    plat_st_r   <= plat_st_nxt;
    pend_lun_r  <= pend_lun_nxt;
    pend_plat_r <= pend_plat_nxt;
    oact_r      <= oact_nxt;
    olun_r      <= olun_nxt;
    oplat_r     <= oplat_nxt;
    olast_r     <= olast_nxt;
  end

  assign out_valid          = ov_r;
  assign out_action         = oact_r;
  assign out_drive_lun      = olun_r;
  assign out_target_platter = oplat_r;
  assign out_last           = olast_r;

  `JPLM_ASSERT_IMP(a_pend_probe, pend_v_r, cmd_r == jplm_pkg::CMD_PROBE, "held stop outside a probe")
  `JPLM_ASSERT_IMP(a_hits_max, 1'b1, hits_r <= jplm_pkg::HIT_W'(jplm_pkg::MAX_RES), "too many probe stops")
  `JPLM_ASSERT_NXT(a_out_hold, ov_r && out_stall, ov_r && $stable(oact_r), "stalled result lost")

endmodule

@@ rtl/core/jukebox_platter_lun_manager.sv @@
// Top level of the jukebox platter LUN manager: config register, sequencer and datapath.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   in_command, in_platter, in_now
//   out_     output     out_valid / out_stall out_action, out_drive_lun,
//                                             out_target_platter, out_last
//   cfg      input      APB psel/penable      paddr, pwdata, prdata (idle_timeout)
//
// A bad platter is rejected at once; access to a loaded platter needs no table scan;
// an unloaded one scans for platters on its LUN; a probe scans, ending at the fifth stop.
// Scans read one platter per cycle, pausing at access stops/releases and output stalls.
// Reset is synchronous; per-entry valid bits clear the table at once, no clearing pass.
// out_stall holds the output register; the sequencer then waits at its next command.
// A new request is taken once the previous one has placed its last result.

module jukebox_platter_lun_manager #(
  parameter int PLATTERS = jplm_pkg::PLATTERS_DEF,
  parameter int LUNS     = jplm_pkg::LUNS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_command,
  input  logic [jplm_pkg::PLAT_W-1:0]   in_platter,
  input  logic [jplm_pkg::TIME_W-1:0]   in_now,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [jplm_pkg::ACT_W-1:0]    out_action,
  output logic [jplm_pkg::LUN_W-1:0]    out_drive_lun,
  output logic [jplm_pkg::PLAT_W-1:0]   out_target_platter,
  output logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [jplm_pkg::CFG_AW-1:0]   paddr,
  input  logic [jplm_pkg::CFG_DW-1:0]   pwdata,
  output logic [jplm_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);

  logic [jplm_pkg::TIME_W-1:0] timeout_r, timeout_nxt;
  logic                        reg_sel;
  jplm_pkg::ctl_t              ctl;
  jplm_pkg::sts_t              sts;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == jplm_pkg::REG_IDLE_TIMEOUT);

  always_comb begin
    timeout_nxt = timeout_r;
    if (psel && penable && pwrite && reg_sel) timeout_nxt = pwdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= jplm_pkg::TIMEOUT_RST;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  assign prdata = reg_sel ? timeout_r : '0;

  jplm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  jplm_dp #(
    .PLATTERS (PLATTERS),
    .LUNS     (LUNS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_command         (in_command),
    .in_platter         (in_platter),
    .in_now             (in_now),
    .idle_timeout       (timeout_r),
    .ctl                (ctl),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_action         (out_action),
    .out_drive_lun      (out_drive_lun),
    .out_target_platter (out_target_platter),
    .out_last           (out_last)
  );

endmodule
